// ===== src/tccs_pkg.sv =====
`default_nettype none
package tccs_pkg;

   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int CELLS    = COLUMNS * ROWS;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int SWEEP_W  = $clog2(CELLS + 1);
   localparam int ROW_W    = $clog2(ROWS);
   localparam int COL_W    = $clog2(COLUMNS);
   localparam int POS_W    = 11;
   localparam int CHAR_W   = 8;
   localparam int CELL_W   = 2 * CHAR_W;
   localparam int TAB_STEP = 4;

   localparam logic [CHAR_W-1:0] CH_BELL = 8'h07;
   localparam logic [CHAR_W-1:0] CH_BS   = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB  = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NL   = 8'h0A;

   localparam logic [1:0] MODE_STREAM = 2'd0;
   localparam logic [1:0] MODE_WRITE  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;
   localparam logic [1:0] MODE_READ   = 2'd3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_TEXT_COLOR = 1'b0;
   localparam logic [CHAR_W-1:0] TEXT_COLOR_RESET = 8'd7;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] char_code;
      logic [7:0] cell_color;
      logic [6:0] column;
      logic [4:0] row;
   } req_type;

   typedef struct packed {
      logic [10:0] cursor_pos;
      logic [15:0] cell_value;
   } rsp_type;

   typedef enum logic [1:0] {
      SWEEP_NONE,
      SWEEP_INIT,
      SWEEP_CLEAR,
      SWEEP_SCROLL
   } sweep_type;

   typedef struct packed {
      logic      load_item;
      logic      exec;
      logic      sweep_clr;
      sweep_type sweep_kind;
      logic      read_capture;
      logic      load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       need_scroll;
      logic       fill_last;
      logic       scroll_last;
   } ctrl_status_type;

endpackage
`default_nettype wire

// ===== src/tccs_ram.sv =====
`default_nettype none
module tccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/tccs_ctrl.sv =====
`default_nettype none
module tccs_ctrl
   import tccs_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_CLEAR,
      ST_SCROLL,
      ST_READ,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep_kind = SWEEP_INIT;
            if (status.fill_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.load_item = req_valid;
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec      = 1'b1;
            cmd.sweep_clr = 1'b1;
            case (status.mode)
               MODE_STREAM: state_in = status.need_scroll ? ST_SCROLL : ST_FINISH;
               MODE_CLEAR:  state_in = ST_CLEAR;
               MODE_READ:   state_in = ST_READ;
               default:     state_in = ST_FINISH;
            endcase
         end
         ST_CLEAR: begin
            cmd.sweep_kind = SWEEP_CLEAR;
            if (status.fill_last) state_in = ST_FINISH;
         end
         ST_SCROLL: begin
            cmd.sweep_kind = SWEEP_SCROLL;
            if (status.scroll_last) state_in = ST_FINISH;
         end
         ST_READ: begin
            cmd.read_capture = 1'b1;
            state_in         = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         req_stall_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != ST_IDLE);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== src/tccs_dpath.sv =====
`default_nettype none
module tccs_dpath
   import tccs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_type               req_data,
   output rsp_type                    rsp_data,
   input  wire ctrl_cmd_type          cmd,
   output ctrl_status_type            status,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       ram_wr_en,
   output logic      [ADDR_W-1:0]     ram_wr_addr,
   output logic      [CELL_W-1:0]     ram_wr_data,
   output logic      [ADDR_W-1:0]     ram_rd_addr,
   input  wire logic [CELL_W-1:0]     ram_rd_data
);

   req_type            item_ff;
   rsp_type            rsp_ff;
   logic [CHAR_W-1:0]  color_ff;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [SWEEP_W-1:0] sweep_ff, sweep_in;
   logic [CELL_W-1:0]  read_val_ff;

   logic [CELL_W-1:0]  blank;
   logic               in_range;
   logic [ADDR_W-1:0]  item_addr;
   logic [ADDR_W-1:0]  cursor_addr;
   logic [COL_W:0]     col_p1;
   logic [COL_W:0]     col_tab;
   logic               advance;
   logic               printable;
   logic [COL_W-1:0]   stream_col;
   logic               csr_hit;

   assign blank     = {color_ff, {CHAR_W{1'b0}}};
   assign in_range  = ({1'b0, item_ff.column} < 8'(COLUMNS)) &&
                      ({1'b0, item_ff.row} < 6'(ROWS));
   assign item_addr   = ADDR_W'(item_ff.row) * ADDR_W'(COLUMNS) + ADDR_W'(item_ff.column);
   assign cursor_addr = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   assign col_p1    = {1'b0, col_ff} + 1'b1;
   assign col_tab   = {1'b0, col_ff} + (COL_W + 1)'(TAB_STEP);

   // stream: cursor motion before any row advance
   always_comb begin
      advance    = 1'b0;
      printable  = 1'b0;
      stream_col = col_ff;
      case (item_ff.char_code)
         CH_BELL: ;
         CH_BS: begin
            if (col_ff != '0) stream_col = col_ff - 1'b1;
         end
         CH_NL: advance = 1'b1;
         CH_TAB: begin
            if (col_tab >= (COL_W + 1)'(COLUMNS)) advance = 1'b1;
            else stream_col = col_tab[COL_W-1:0];
         end
         default: begin
            printable = 1'b1;
            if (col_p1 == (COL_W + 1)'(COLUMNS)) advance = 1'b1;
            else stream_col = col_p1[COL_W-1:0];
         end
      endcase
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.exec) begin
         case (item_ff.mode)
            MODE_STREAM: begin
               col_in = stream_col;
               if (advance) begin
                  col_in = '0;
                  if (row_ff != ROW_W'(ROWS - 1)) row_in = row_ff + 1'b1;
               end
            end
            MODE_CLEAR: begin
               row_in = '0;
               col_in = '0;
            end
            default: ;
         endcase
      end
   end

   assign status.mode        = item_ff.mode;
   assign status.need_scroll = advance && (row_ff == ROW_W'(ROWS - 1));
   assign status.fill_last   = (sweep_ff == SWEEP_W'(CELLS - 1));
   assign status.scroll_last = (sweep_ff == SWEEP_W'(CELLS));

   always_comb begin
      if (cmd.sweep_clr) sweep_in = '0;
      else if (cmd.sweep_kind != SWEEP_NONE) sweep_in = sweep_ff + 1'b1;
      else sweep_in = sweep_ff;
   end

   // scroll: read cell s+COLUMNS and write it back to s in the next cycle; the last row gets blanks
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cursor_addr;
      ram_wr_data = {color_ff, item_ff.char_code};
      ram_rd_addr = item_addr;
      case (cmd.sweep_kind)
         SWEEP_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(sweep_ff);
            ram_wr_data = '0;
         end
         SWEEP_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(sweep_ff);
            ram_wr_data = blank;
         end
         SWEEP_SCROLL: begin
            ram_wr_en   = (sweep_ff != '0);
            ram_wr_addr = ADDR_W'(sweep_ff - 1'b1);
            ram_wr_data = (sweep_ff <= SWEEP_W'(CELLS - COLUMNS)) ? ram_rd_data : blank;
            if (sweep_ff < SWEEP_W'(CELLS - COLUMNS)) begin
               ram_rd_addr = ADDR_W'(sweep_ff + SWEEP_W'(COLUMNS));
            end else begin
               ram_rd_addr = '0;
            end
         end
         default: begin
            if (cmd.exec && item_ff.mode == MODE_STREAM) begin
               ram_wr_en = printable;
            end else if (cmd.exec && item_ff.mode == MODE_WRITE) begin
               ram_wr_en   = in_range;
               ram_wr_addr = item_addr;
               ram_wr_data = {item_ff.cell_color, item_ff.char_code};
            end
         end
      endcase
   end

   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_TEXT_COLOR);
   assign csr_prdata = csr_hit ? CSR_DATA_W'(color_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= TEXT_COLOR_RESET;
         row_ff   <= '0;
         col_ff   <= '0;
         sweep_ff <= '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
            color_ff <= csr_pwdata[CHAR_W-1:0];
         end
         row_ff   <= row_in;
         col_ff   <= col_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) item_ff <= req_data;
      if (cmd.read_capture) read_val_ff <= in_range ? ram_rd_data : '0;
      if (cmd.load_rsp) begin
         rsp_ff.cursor_pos <= POS_W'(cursor_addr);
         rsp_ff.cell_value <= (item_ff.mode == MODE_READ) ? read_val_ff : '0;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ===== src/text_console_cursor_scroll.sv =====
// Text console engine: a ROWS x COLUMNS store of {attribute, character} cells and a cursor.
// Request channel (req_valid/req_stall/req_data): one transfer per command, mode selects
// stream character, positioned cell write, clear screen or cell read.
// Response channel (rsp_valid/rsp_stall/rsp_data): exactly one transfer per command with the
// cursor index after the command and, for a read, the cell value (else 0).
// Commands run one at a time. A read waits on the registered RAM read of the cell; a clear
// writes one cell per cycle over the whole store; a stream that scrolls copies one cell per
// cycle through the single write port of the cell RAM, the bottom row filled with blanks in
// the same pass.
// A finished response sits in an output register; the next command is taken while it waits,
// and only the following response holds back until rsp_stall drops.
// Reset: cursor to 0, text_color to 7, then a clearing pass zeroes the RAM with req_stall
// high. Configuration writes over the csr_ port are taken at any time; text_color is at
// byte address 0. pready is tied high.
`default_nettype none
module text_console_cursor_scroll
   import tccs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   ctrl_cmd_type      cmd;
   ctrl_status_type   status;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;

   assign csr_pready = 1'b1;

   tccs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tccs_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .status      (status),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   tccs_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
`default_nettype wire
